/* rtl/tss_pkg.sv */
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types and constants of the timeslice slot scheduler.
// ----------------------------------------------------------------------------
package tss_pkg;

   localparam int RESULT_LIMIT = 8;
   localparam int FIRE_CNT_W = 4;

   localparam logic [1:0] KIND_REG  = 2'd0;
   localparam logic [1:0] KIND_FIRE = 2'd1;
   localparam logic [1:0] KIND_NONE = 2'd2;

   typedef struct packed {
      logic latch_req;
      logic clr_j;
      logic inc_j;
      logic rs_start;
      logic rs_write;
      logic set_ldiv;
      logic sr_init;
      logic sr_step;
      logic sr_next;
      logic store;
      logic tk_start;
      logic tk_fire;
      logic tk_end;
      logic refuse;
   } tss_cmd_type;

   typedef struct packed {
      logic refuse_cond;
      logic grow;
      logic j_end;
      logic div_done;
      logic rd_div_zero;
      logic last_cand;
   } tss_status_type;

endpackage

/* rtl/tss_div.sv */
// ----------------------------------------------------------------------------
// tss_div
// Restoring divider, 16-bit dividend by 8-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module tss_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] dividend,
   input  logic [7:0]  divisor,
   output logic        done,
   output logic [15:0] quotient,
   output logic [7:0]  remainder
);

   logic        run_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic [15:0] quo_ff;
   logic [7:0]  rem_ff;
   logic [7:0]  div_ff;
   logic [8:0]  trial;
   logic        ge;
   logic [8:0]  diff;
   logic [7:0]  rem_in;
   logic [15:0] quo_in;

   assign trial  = {rem_ff, quo_ff[15]};
   assign ge     = trial >= {1'b0, div_ff};
   assign diff   = trial - {1'b0, div_ff};
   assign rem_in = ge ? diff[7:0] : trial[7:0];
   assign quo_in = {quo_ff[14:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= 5'd16;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= 8'd0;
         div_ff <= divisor;
      end else if (run_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

/* rtl/tss_ctrl.sv */
// ----------------------------------------------------------------------------
// tss_ctrl
// Sequencer of the slot scheduler: registration, rescale, search and tick.
// ----------------------------------------------------------------------------
module tss_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    req_func,
   input  tss_pkg::tss_status_type status,
   output tss_pkg::tss_cmd_type    cmd,
   output logic                    busy
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_RS_RD   = 4'd1;
   localparam logic [3:0] S_RS_CHK  = 4'd2;
   localparam logic [3:0] S_RS_DIV  = 4'd3;
   localparam logic [3:0] S_SR_INIT = 4'd4;
   localparam logic [3:0] S_SR_WAIT = 4'd5;
   localparam logic [3:0] S_SR_CMP  = 4'd6;
   localparam logic [3:0] S_STORE   = 4'd7;
   localparam logic [3:0] S_TK_RD   = 4'd8;
   localparam logic [3:0] S_TK_CHK  = 4'd9;
   localparam logic [3:0] S_TK_DIV  = 4'd10;
   localparam logic [3:0] S_TK_END  = 4'd11;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_func) begin
                  cmd.clr_j = 1'b1;
                  state_in  = S_TK_RD;
               end else if (status.refuse_cond) begin
                  cmd.refuse = 1'b1;
               end else begin
                  cmd.latch_req = 1'b1;
                  if (status.grow) begin
                     cmd.clr_j = 1'b1;
                     state_in  = S_RS_RD;
                  end else begin
                     state_in = S_SR_INIT;
                  end
               end
            end
         end
         S_RS_RD: state_in = S_RS_CHK;
         S_RS_CHK: begin
            if (status.j_end) begin
               cmd.set_ldiv = 1'b1;
               state_in     = S_SR_INIT;
            end else begin
               cmd.rs_start = 1'b1;
               state_in     = S_RS_DIV;
            end
         end
         S_RS_DIV: begin
            if (status.div_done) begin
               cmd.rs_write = 1'b1;
               cmd.inc_j    = 1'b1;
               state_in     = S_RS_RD;
            end
         end
         S_SR_INIT: begin
            cmd.sr_init = 1'b1;
            state_in    = S_SR_WAIT;
         end
         S_SR_WAIT: state_in = S_SR_CMP;
         S_SR_CMP: begin
            if (status.j_end) begin
               cmd.sr_next = 1'b1;
               state_in    = status.last_cand ? S_STORE : S_SR_WAIT;
            end else begin
               cmd.sr_step = 1'b1;
               cmd.inc_j   = 1'b1;
               state_in    = S_SR_WAIT;
            end
         end
         S_STORE: begin
            cmd.store = 1'b1;
            state_in  = S_IDLE;
         end
         S_TK_RD: state_in = S_TK_CHK;
         S_TK_CHK: begin
            if (status.j_end) begin
               state_in = S_TK_END;
            end else if (status.rd_div_zero) begin
               cmd.inc_j = 1'b1;
               state_in  = S_TK_RD;
            end else begin
               cmd.tk_start = 1'b1;
               state_in     = S_TK_DIV;
            end
         end
         S_TK_DIV: begin
            if (status.div_done) begin
               cmd.tk_fire = 1'b1;
               cmd.inc_j   = 1'b1;
               state_in    = S_TK_RD;
            end
         end
         S_TK_END: begin
            cmd.tk_end = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = state_ff != S_IDLE;

endmodule

/* rtl/tss_dp.sv */
// ----------------------------------------------------------------------------
// tss_dp
// Datapath of the slot scheduler: task table, counters, search and results.
// ----------------------------------------------------------------------------
module tss_dp #(
   parameter int MAX_TASKS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tss_pkg::tss_cmd_type    cmd,
   input  logic [7:0]              req_divider,
   input  logic [7:0]              req_task_id,
   output tss_pkg::tss_status_type status,
   output logic                    rsp_strobe,
   output logic [1:0]              rsp_kind,
   output logic                    rsp_accepted,
   output logic [7:0]              rsp_slot,
   output logic [7:0]              rsp_fired_id,
   output logic                    rsp_last
);

   localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW = $clog2(MAX_TASKS + 1);

   logic [7:0] slot_mem [MAX_TASKS];
   logic [7:0] div_mem  [MAX_TASKS];
   logic [7:0] task_mem [MAX_TASKS];

   logic [CW-1:0] count_ff;
   logic [CW-1:0] j_ff;
   logic [7:0]    ldiv_ff;
   logic [7:0]    tick_ff;
   logic [7:0]    rdiv_ff;
   logic [7:0]    rid_ff;
   logic [7:0]    i_ff;
   logic [7:0]    mind_ff;
   logic [7:0]    best_dist_ff;
   logic [7:0]    best_slot_ff;
   logic [7:0]    rd_slot_ff;
   logic [7:0]    rd_div_ff;
   logic [7:0]    rd_task_ff;
   logic          pend_v_ff;
   logic [7:0]    pend_slot_ff;
   logic [7:0]    pend_id_ff;
   logic [tss_pkg::FIRE_CNT_W-1:0] nfire_ff;
   logic          strobe_ff;
   logic [1:0]    kind_ff;
   logic          acc_ff;
   logic [7:0]    slot_ff;
   logic [7:0]    id_ff;
   logic          last_ff;

   logic          dv_start;
   logic [15:0]   dv_dividend;
   logic [7:0]    dv_divisor;
   logic          dv_done;
   logic [15:0]   dv_quo;
   logic [7:0]    dv_rem;
   logic [15:0]   rs_prod;
   logic [8:0]    tk_sum;
   logic [7:0]    d_lin;
   logic [7:0]    d_alt;
   logic [7:0]    cand_dist;
   logic [8:0]    tick_inc;
   logic          fire_ok;

   assign rs_prod     = rd_slot_ff * rdiv_ff;
   assign tk_sum      = {1'b0, tick_ff} + {1'b0, rd_slot_ff};
   assign dv_start    = cmd.rs_start | cmd.tk_start;
   assign dv_dividend = cmd.rs_start ? rs_prod : {7'd0, tk_sum};
   assign dv_divisor  = cmd.rs_start ? ldiv_ff : rd_div_ff;

   tss_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (dv_start),
      .dividend  (dv_dividend),
      .divisor   (dv_divisor),
      .done      (dv_done),
      .quotient  (dv_quo),
      .remainder (dv_rem)
   );

   assign d_lin     = (i_ff >= rd_slot_ff) ? i_ff - rd_slot_ff : rd_slot_ff - i_ff;
   assign d_alt     = (d_lin <= ldiv_ff) ? ldiv_ff - d_lin : d_lin;
   assign cand_dist = (d_alt < d_lin) ? d_alt : d_lin;
   assign tick_inc  = {1'b0, tick_ff} + 9'd1;
   assign fire_ok   = (dv_rem == 8'd0) &&
                      (nfire_ff < tss_pkg::FIRE_CNT_W'(tss_pkg::RESULT_LIMIT));

   assign status.refuse_cond = (count_ff >= CW'(MAX_TASKS)) || (req_divider == 8'd0);
   assign status.grow        = req_divider > ldiv_ff;
   assign status.j_end       = j_ff == count_ff;
   assign status.div_done    = dv_done;
   assign status.rd_div_zero = rd_div_ff == 8'd0;
   assign status.last_cand   = ({1'b0, i_ff} + 9'd1) == {1'b0, ldiv_ff};

   always_ff @(posedge clock) begin
      rd_slot_ff <= slot_mem[j_ff[IW-1:0]];
      rd_div_ff  <= div_mem[j_ff[IW-1:0]];
      rd_task_ff <= task_mem[j_ff[IW-1:0]];
      if (cmd.rs_write) begin
         slot_mem[j_ff[IW-1:0]] <= dv_quo[7:0];
      end else if (cmd.store) begin
         slot_mem[count_ff[IW-1:0]] <= best_slot_ff;
      end
      if (cmd.store) begin
         div_mem[count_ff[IW-1:0]]  <= rdiv_ff;
         task_mem[count_ff[IW-1:0]] <= rid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         ldiv_ff   <= 8'd0;
         tick_ff   <= 8'd0;
         j_ff      <= '0;
         pend_v_ff <= 1'b0;
         nfire_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         if (cmd.clr_j || cmd.sr_init) begin
            j_ff <= '0;
         end else if (cmd.inc_j) begin
            j_ff <= j_ff + CW'(1);
         end else if (cmd.sr_next) begin
            j_ff <= '0;
         end
         if (cmd.clr_j) begin
            pend_v_ff <= 1'b0;
            nfire_ff  <= '0;
         end
         if (cmd.set_ldiv) begin
            ldiv_ff <= rdiv_ff;
         end
         if (cmd.store) begin
            count_ff  <= count_ff + CW'(1);
            strobe_ff <= 1'b1;
         end
         if (cmd.refuse) begin
            strobe_ff <= 1'b1;
         end
         if (cmd.tk_fire && fire_ok) begin
            pend_v_ff <= 1'b1;
            nfire_ff  <= nfire_ff + tss_pkg::FIRE_CNT_W'(1);
            if (pend_v_ff) begin
               strobe_ff <= 1'b1;
            end
         end
         if (cmd.tk_end) begin
            strobe_ff <= 1'b1;
            pend_v_ff <= 1'b0;
            if (ldiv_ff != 8'd0) begin
               tick_ff <= (tick_inc >= {1'b0, ldiv_ff}) ? 8'd0 : tick_inc[7:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         rdiv_ff <= req_divider;
         rid_ff  <= req_task_id;
      end
      if (cmd.sr_init) begin
         i_ff         <= 8'd0;
         mind_ff      <= ldiv_ff;
         best_dist_ff <= 8'd0;
         best_slot_ff <= 8'd0;
      end
      if (cmd.sr_step && (cand_dist < mind_ff)) begin
         mind_ff <= cand_dist;
      end
      if (cmd.sr_next) begin
         if (mind_ff > best_dist_ff) begin
            best_dist_ff <= mind_ff;
            best_slot_ff <= i_ff;
         end
         i_ff    <= i_ff + 8'd1;
         mind_ff <= ldiv_ff;
      end
      if (cmd.tk_fire && fire_ok) begin
         pend_slot_ff <= rd_slot_ff;
         pend_id_ff   <= rd_task_ff;
      end
      if (cmd.refuse) begin
         kind_ff <= tss_pkg::KIND_REG;
         acc_ff  <= 1'b0;
         slot_ff <= 8'd0;
         id_ff   <= 8'd0;
         last_ff <= 1'b1;
      end else if (cmd.store) begin
         kind_ff <= tss_pkg::KIND_REG;
         acc_ff  <= 1'b1;
         slot_ff <= best_slot_ff;
         id_ff   <= 8'd0;
         last_ff <= 1'b1;
      end else if (cmd.tk_fire) begin
         kind_ff <= tss_pkg::KIND_FIRE;
         acc_ff  <= 1'b0;
         slot_ff <= pend_slot_ff;
         id_ff   <= pend_id_ff;
         last_ff <= 1'b0;
      end else if (cmd.tk_end) begin
         kind_ff <= pend_v_ff ? tss_pkg::KIND_FIRE : tss_pkg::KIND_NONE;
         acc_ff  <= 1'b0;
         slot_ff <= pend_v_ff ? pend_slot_ff : 8'd0;
         id_ff   <= pend_v_ff ? pend_id_ff : 8'd0;
         last_ff <= 1'b1;
      end
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_kind     = kind_ff;
   assign rsp_accepted = acc_ff;
   assign rsp_slot     = slot_ff;
   assign rsp_fired_id = id_ff;
   assign rsp_last     = last_ff;

endmodule

/* rtl/timeslice_slot_scheduler_top.sv */
// ----------------------------------------------------------------------------
// timeslice_slot_scheduler_top
// Slot scheduler for periodic tasks with phase spreading and tick firing.
//
// An item is taken when start is high and busy is low. A register item
// (req_func 0) stores a task or is refused and gives one reply; a tick item
// (req_func 1) gives one result per firing task, up to RESULT_LIMIT, or one
// result when nothing fires, and rsp_last marks the final result of the
// item. Each result is shown for one cycle with rsp_strobe high; the
// receiver cannot stall the block. A refused register item is answered in
// the cycle after it is taken. When the largest divider grows, a stored
// register item first rescales the slots in the table through the shared
// divider; it then scans each candidate slot against the table and is
// answered with the best one. A tick runs each entry with a nonzero divider
// through the shared bit-serial divider. Busy drops in the cycle of the final
// result, and the next item can be taken at the end of that cycle.
// Reset empties the table and clears the tick count and largest divider.
// ----------------------------------------------------------------------------
module timeslice_slot_scheduler_top #(
   parameter int MAX_TASKS = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_func,
   input  logic [7:0] req_divider,
   input  logic [7:0] req_task_id,
   output logic       rsp_strobe,
   output logic [1:0] rsp_kind,
   output logic       rsp_accepted,
   output logic [7:0] rsp_slot,
   output logic [7:0] rsp_fired_id,
   output logic       rsp_last
);

   tss_pkg::tss_cmd_type    cmd;
   tss_pkg::tss_status_type status;

   tss_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_func),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   tss_dp #(
      .MAX_TASKS (MAX_TASKS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_divider  (req_divider),
      .req_task_id  (req_task_id),
      .status       (status),
      .rsp_strobe   (rsp_strobe),
      .rsp_kind     (rsp_kind),
      .rsp_accepted (rsp_accepted),
      .rsp_slot     (rsp_slot),
      .rsp_fired_id (rsp_fired_id),
      .rsp_last     (rsp_last)
   );

   a_reg_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_kind == tss_pkg::KIND_REG) |-> rsp_last)
      else $error("register reply without last");

   a_acc_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_accepted |-> (rsp_kind == tss_pkg::KIND_REG))
      else $error("accepted flag on a tick result");

   a_none_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_kind == tss_pkg::KIND_NONE) |-> rsp_last && (rsp_slot == 8'd0))
      else $error("empty tick result malformed");

   a_refuse_reply: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_func && (req_divider == 8'd0) |=> rsp_strobe && !rsp_accepted)
      else $error("zero divider not refused at once");

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// Testbench for timeslice_slot_scheduler_top
// Drives register and tick items through the start/busy handshake, predicts
// every result with an independent model of the slot table, and compares
// each strobed result, all fields at once, in order.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TASK_CAP = 8;
   localparam logic FUNC_REGISTER = 1'b0;
   localparam logic FUNC_TICK = 1'b1;
   localparam int CYCLE_LIMIT = 4000000;

   typedef struct packed {
      logic [1:0] kind;
      logic       accepted;
      logic [7:0] slot;
      logic [7:0] fired_id;
      logic       last;
   } sched_result_type;

   class slot_table_scoreboard;
      int unsigned n_tasks;
      int unsigned top_div;
      int unsigned phase;
      logic [7:0] slot_of[TASK_CAP];
      logic [7:0] div_of[TASK_CAP];
      logic [7:0] id_of[TASK_CAP];
      sched_result_type pending[$];
      int errors;

      function void clear();
         n_tasks = 0;
         top_div = 0;
         phase = 0;
         pending.delete();
         errors = 0;
      endfunction

      function int unsigned ring_gap(int unsigned a, int unsigned b, int unsigned m);
         int unsigned d;
         int unsigned alt;
         d = (a >= b) ? a - b : b - a;
         alt = (d <= m) ? m - d : d;
         return (alt < d) ? alt : d;
      endfunction

      function void note_item(logic func, logic [7:0] dv, logic [7:0] id);
         sched_result_type r;
         int unsigned best_slot, best_gap, g, nfire;
         r = '0;
         if (func == FUNC_REGISTER) begin
            r.kind = tss_pkg::KIND_REG;
            r.last = 1'b1;
            if (n_tasks < TASK_CAP && dv != 0) begin
               if (dv > top_div) begin
                  for (int i = 0; i < n_tasks; i++)
                     slot_of[i] = (top_div != 0) ? 8'((slot_of[i] * dv) / top_div) : 8'd0;
                  top_div = dv;
               end
               best_slot = 0;
               best_gap = 0;
               for (int c = 0; c < top_div; c++) begin
                  g = top_div;
                  for (int j = 0; j < n_tasks; j++)
                     if (ring_gap(c, slot_of[j], top_div) < g)
                        g = ring_gap(c, slot_of[j], top_div);
                  if (g > best_gap) begin
                     best_gap = g;
                     best_slot = c;
                  end
               end
               slot_of[n_tasks] = 8'(best_slot);
               div_of[n_tasks] = dv;
               id_of[n_tasks] = id;
               n_tasks++;
               r.accepted = 1'b1;
               r.slot = 8'(best_slot);
            end
            pending.push_back(r);
         end else begin
            nfire = 0;
            for (int i = 0; i < n_tasks; i++) begin
               if (div_of[i] != 0 && (phase + slot_of[i]) % div_of[i] == 0
                     && nfire < tss_pkg::RESULT_LIMIT) begin
                  r = '0;
                  r.kind = tss_pkg::KIND_FIRE;
                  r.slot = slot_of[i];
                  r.fired_id = id_of[i];
                  pending.push_back(r);
                  nfire++;
               end
            end
            if (nfire == 0) begin
               r = '0;
               r.kind = tss_pkg::KIND_NONE;
               r.last = 1'b1;
               pending.push_back(r);
            end else begin
               pending[pending.size() - 1].last = 1'b1;
            end
            if (top_div != 0) begin
               phase++;
               if (phase >= top_div)
                  phase = 0;
            end
         end
      endfunction

      function void check_result(sched_result_type got);
         sched_result_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("Unexpected result: %p", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display("Mismatch: expected %p, actual %p", want, got);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_func = 1'b0;
   logic [7:0] req_divider = 8'd0;
   logic [7:0] req_task_id = 8'd0;
   logic rsp_strobe;
   logic [1:0] rsp_kind;
   logic rsp_accepted;
   logic [7:0] rsp_slot;
   logic [7:0] rsp_fired_id;
   logic rsp_last;

   slot_table_scoreboard board;
   int idle_pct = 0;
   int cycles = 0;

   timeslice_slot_scheduler_top #(.MAX_TASKS(TASK_CAP)) u_top (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_strobe)
         board.check_result({rsp_kind, rsp_accepted, rsp_slot, rsp_fired_id, rsp_last});

   task automatic send_item(logic func, logic [7:0] dv, logic [7:0] id);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_func <= func;
      req_divider <= dv;
      req_task_id <= id;
      do
         @(posedge clock);
      while (busy);
      board.note_item(func, dv, id);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (board.pending.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic tick_burst(int n);
      for (int i = 0; i < n; i++)
         send_item(FUNC_TICK, 8'($urandom), 8'($urandom));
   endtask

   task automatic random_divider(output logic [7:0] dv);
      case ($urandom_range(9))
         0: dv = 8'd255;
         1: dv = 8'd0;
         2, 3: dv = 8'($urandom_range(255, 1));
         default: dv = 8'($urandom_range(16, 1));
      endcase
   endtask

   initial begin
      logic [7:0] dv;
      board = new();
      board.clear();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: tick before any divider, zero divider, extremes, table full.
      send_item(FUNC_TICK, 8'hff, 8'hff);
      send_item(FUNC_REGISTER, 8'd0, 8'h5a);
      send_item(FUNC_REGISTER, 8'd1, 8'h00);
      send_item(FUNC_REGISTER, 8'd1, 8'hff);
      tick_burst(2);
      send_item(FUNC_REGISTER, 8'd2, 8'haa);
      send_item(FUNC_REGISTER, 8'd255, 8'h55);
      send_item(FUNC_REGISTER, 8'd128, 8'h0f);
      send_item(FUNC_REGISTER, 8'd3, 8'hf0);
      send_item(FUNC_REGISTER, 8'd4, 8'h11);
      send_item(FUNC_REGISTER, 8'd1, 8'h22);
      send_item(FUNC_REGISTER, 8'd5, 8'h33);
      send_item(FUNC_REGISTER, 8'd7, 8'h44);
      tick_burst(6);
      drain();

      // Random sessions: registers against the full table, mixed with ticks.
      for (int phase_no = 0; phase_no < 3; phase_no++) begin
         idle_pct = (phase_no == 0) ? 34 : (phase_no == 1) ? 69 : 0;
         for (int s = 0; s < 2; s++) begin
            for (int k = 0; k < 10; k++) begin
               random_divider(dv);
               send_item(FUNC_REGISTER, dv, 8'($urandom));
               if ($urandom_range(3) == 0)
                  tick_burst($urandom_range(3, 1));
            end
            tick_burst(18);
            drain();
            // The table never empties, so later sessions find it full and their
            // registers are refused; ticks over a full table exercise many firings.
         end
      end
      drain();
      if (board.errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
